// File: rtl/core/dsf_pkg.sv
`default_nettype none

package dsf_pkg;

  // Field widths.
  localparam int DSF_TAG_BITS = 16;
  localparam int FRAC_BITS    = 16;
  localparam int WORD_W       = 32;
  localparam int MASS_W       = 31;
  localparam int SOFT_W       = 16;
  localparam int WIDE_W       = 64;
  localparam int LEN_W        = WORD_W + 1;

  // A clamped product magnitude never exceeds 2^(MAG_W-1).
  localparam int MAG_W        = 62;

  localparam logic [SOFT_W-1:0] SOFT_RESET = SOFT_W'(1);

  // Pipeline depth of the wide multiplier.
  localparam int MUL_LAT = 4;

  // Result of a scaled multiply: clamped magnitude and its saturation flag.
  typedef struct packed {
    logic             sat;
    logic [MAG_W-1:0] mag;
  } prod_t;

endpackage

`default_nettype wire

// File: rtl/core/damped_spring_force_top.sv
// Damped spring force unit.
// Input channel: in_valid/in_ready with one spring per request (tag, offsets,
// relative velocities, masses, stiffness, rest length, damping). Output
// channel: out_valid/out_ready with the tag, the saturated Q15.16 force, the
// separation and an overflow flag. The length softening register is written
// through cfg_we/cfg_data; the user must do so only while no request is in
// flight, as the block itself does not enforce it. The pipeline has 176
// register stages: a 32-stage square root, two 64-stage dividers in series
// (the second divides by the length once more) and two 4-stage multipliers
// make up most of them. A new request is accepted on every cycle in which
// the output does not stall.
// The whole pipeline advances together. When a result waits on the output
// and out_ready is low, every stage holds and in_ready drops until the
// result is taken; nothing is lost or repeated.
// Reset clears all valid bits and sets the softening to one LSB; data
// registers are not cleared.
`default_nettype none

module damped_spring_force_top import dsf_pkg::*; #(
  parameter int TAG_BITS = DSF_TAG_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [SOFT_W-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [TAG_BITS-1:0]      spring_tag,
  input  logic signed [WORD_W-1:0] offset_x,
  input  logic signed [WORD_W-1:0] offset_y,
  input  logic signed [WORD_W-1:0] offset_z,
  input  logic signed [WORD_W-1:0] rel_vel_x,
  input  logic signed [WORD_W-1:0] rel_vel_y,
  input  logic signed [WORD_W-1:0] rel_vel_z,
  input  logic [MASS_W-1:0]        mass_first,
  input  logic [MASS_W-1:0]        mass_second,
  input  logic [MASS_W-1:0]        stiffness,
  input  logic [MASS_W-1:0]        rest_length,
  input  logic [MASS_W-1:0]        damping,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [TAG_BITS-1:0]      tag_out,
  output logic signed [WORD_W-1:0] force_x,
  output logic signed [WORD_W-1:0] force_y,
  output logic signed [WORD_W-1:0] force_z,
  output logic signed [WORD_W-1:0] sep_x,
  output logic signed [WORD_W-1:0] sep_y,
  output logic signed [WORD_W-1:0] sep_z,
  output logic                     overflow
);

  localparam int SQ_LAT  = WIDE_W / 2;
  localparam int DIV_LAT = WIDE_W;
  localparam int LAT     = 3 + SQ_LAT + 3 + DIV_LAT + 1 + DIV_LAT + 2 * MUL_LAT + 1;

  localparam logic signed [WIDE_W-1:0] F_MAX =
    $signed({{(WIDE_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}});
  localparam logic signed [WIDE_W-1:0] F_MIN =
    $signed({{(WIDE_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}});

  typedef struct packed {
    logic [TAG_BITS-1:0]    tag;
    logic [2:0][WORD_W-1:0] sep;
    logic [2:0][WORD_W-1:0] mag;
  } geo_t;

  typedef struct packed {
    geo_t              geo;
    logic [MASS_W-1:0] m1;
    logic [MASS_W-1:0] m2;
    logic [MASS_W-1:0] ks;
    logic [MASS_W-1:0] rs0;
    logic [MASS_W-1:0] gam;
  } spring_t;

  typedef struct packed {
    spring_t                sp;
    logic [2:0][WIDE_W-1:0] pm;
    logic [2:0]             pneg;
  } side_a_t;

  typedef struct packed {
    geo_t              geo;
    logic [LEN_W-1:0]  len;
    logic              sneg;
    logic              dotneg;
    logic              lnz;
    logic              don;
    logic [MASS_W-1:0] gam;
  } side_c_t;

  typedef struct packed {
    geo_t              geo;
    logic              sneg;
    logic              dotneg;
    logic              don;
    logic [WIDE_W-1:0] fac;
    logic [WIDE_W-1:0] gm;
  } side_d_t;

  typedef struct packed {
    geo_t              geo;
    logic              sneg;
    logic              dotneg;
    logic              don;
    logic [WIDE_W-1:0] fac;
  } side_e_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]    tag;
    logic [2:0][WORD_W-1:0] sep;
    logic                   sneg;
    logic                   dotneg;
    logic                   dfsat;
  } side_f_t;

  logic adv;
  logic [LAT-1:0] vld;
  logic [SOFT_W-1:0] softening;

  logic [2:0][WORD_W-1:0] in_d, in_v;

  spring_t                r1_sp;
  logic [2:0][WORD_W-1:0] r1_v;
  spring_t                r2_sp;
  logic [WIDE_W-1:0]      r2_sq [3];
  logic signed [WIDE_W-1:0] r2_pr [3];
  side_a_t                r3_side;
  logic [WIDE_W-1:0]      r3_sumsq;

  side_a_t           sa_q;
  logic [WORD_W-1:0] root;
  logic [WIDE_W-1:0] pos_sum, neg_sum;

  spring_t           a_sp;
  logic [LEN_W-1:0]  a_len;
  logic [WIDE_W-1:0] a_pos, a_neg;

  logic [LEN_W-1:0]  rs0_ext;
  spring_t           b_sp;
  logic [LEN_W-1:0]  b_len, b_stretch;
  logic              b_lnz, b_sneg, b_dotneg;
  logic [WIDE_W-1:0] b_dotmag;
  logic [2*MASS_W-1:0] b_mprod;
  logic [MASS_W:0]   b_msum;

  side_c_t           c_side;
  logic [WIDE_W-1:0] c_kprod, c_dotmag;
  logic [2*MASS_W-1:0] c_mprod;
  logic [MASS_W:0]   c_msum;

  logic [WIDE_W-1:0] fac_q, dldt_q, mbar_q;
  side_c_t           sc_q;
  logic [2*MASS_W-1:0] gm_full;

  side_d_t           d_side;
  logic [WIDE_W-1:0] d_snum;
  logic [LEN_W-1:0]  d_len;

  logic [WIDE_W-1:0] s_q;
  side_d_t           sd_q;
  side_e_t           se_in, se_q;
  prod_t             df_res;
  side_f_t           sf_in, sf_q;
  logic [WIDE_W-1:0] dm_a;
  prod_t             e_res [3];
  prod_t             m_res [3];

  logic signed [WIDE_W-1:0] e_s [3];
  logic signed [WIDE_W-1:0] m_s [3];
  logic signed [WIDE_W-1:0] diff [3];
  logic [2:0]               g_sat;
  logic [2:0][WORD_W-1:0]   g_force;
  logic [2:0][WORD_W-1:0]   f_q;
  logic [2:0][WORD_W-1:0]   sep_q;

  // The whole pipeline moves unless a result waits on the output.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // Length softening register.
  always_ff @(posedge clk) begin
    if (rst) begin
      softening <= SOFT_RESET;
    end else if (cfg_we) begin
      softening <= cfg_data;
    end
  end

  assign in_d = {offset_z, offset_y, offset_x};
  assign in_v = {rel_vel_z, rel_vel_y, rel_vel_x};

  // Front stages: magnitudes, squares and dot product terms.
  always_ff @(posedge clk) begin
    if (adv) begin
      r1_sp.geo.tag <= spring_tag;
      r1_sp.geo.sep <= in_d;
      for (int k = 0; k < 3; k++) begin
        r1_sp.geo.mag[k] <= in_d[k][WORD_W-1] ? ~in_d[k] + WORD_W'(1) : in_d[k];
      end
      r1_v      <= in_v;
      r1_sp.m1  <= mass_first;
      r1_sp.m2  <= mass_second;
      r1_sp.ks  <= stiffness;
      r1_sp.rs0 <= rest_length;
      r1_sp.gam <= damping;

      r2_sp <= r1_sp;
      for (int k = 0; k < 3; k++) begin
        r2_sq[k] <= r1_sp.geo.mag[k] * r1_sp.geo.mag[k];
        r2_pr[k] <= $signed(r1_sp.geo.sep[k]) * $signed(r1_v[k]);
      end

      r3_side.sp <= r2_sp;
      r3_sumsq   <= r2_sq[0] + r2_sq[1] + r2_sq[2];
      for (int k = 0; k < 3; k++) begin
        r3_side.pneg[k] <= r2_pr[k][WIDE_W-1];
        r3_side.pm[k]   <= r2_pr[k][WIDE_W-1] ? WIDE_W'(-r2_pr[k]) : WIDE_W'(r2_pr[k]);
      end
    end
  end

  dsf_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (r3_sumsq),
    .root (root)
  );

  dsf_delay #(.WIDTH($bits(side_a_t)), .DEPTH(SQ_LAT)) u_dly_a (
    .clk  (clk),
    .en   (adv),
    .din  (r3_side),
    .dout (sa_q)
  );

  // Positive and negative parts of the dot product.
  always_comb begin
    pos_sum = '0;
    neg_sum = '0;
    for (int k = 0; k < 3; k++) begin
      if (sa_q.pneg[k]) begin
        neg_sum = neg_sum + sa_q.pm[k];
      end else begin
        pos_sum = pos_sum + sa_q.pm[k];
      end
    end
  end

  assign rs0_ext = LEN_W'(a_sp.rs0);
  assign gm_full = sc_q.gam * mbar_q[MASS_W-1:0];

  // Length, stretch, dot product and the operands of the first divisions.
  always_ff @(posedge clk) begin
    if (adv) begin
      a_sp  <= sa_q.sp;
      a_len <= LEN_W'(root) + LEN_W'(softening);
      a_pos <= pos_sum;
      a_neg <= neg_sum;

      b_sp      <= a_sp;
      b_len     <= a_len;
      b_lnz     <= a_len != '0;
      b_sneg    <= a_len < rs0_ext;
      b_stretch <= (a_len < rs0_ext) ? rs0_ext - a_len : a_len - rs0_ext;
      b_dotneg  <= a_pos < a_neg;
      b_dotmag  <= (a_pos < a_neg) ? a_neg - a_pos : a_pos - a_neg;
      b_mprod   <= a_sp.m1 * a_sp.m2;
      b_msum    <= {1'b0, a_sp.m1} + {1'b0, a_sp.m2};

      c_side.geo    <= b_sp.geo;
      c_side.len    <= b_len;
      c_side.sneg   <= b_sneg;
      c_side.dotneg <= b_dotneg;
      c_side.lnz    <= b_lnz;
      c_side.don    <= (b_sp.gam != '0) && (b_msum != '0) && b_lnz;
      c_side.gam    <= b_sp.gam;
      c_kprod       <= b_sp.ks * b_stretch;
      c_dotmag      <= b_dotmag;
      c_mprod       <= b_mprod;
      c_msum        <= b_msum;
    end
  end

  dsf_div #(.NUM_W(WIDE_W), .DEN_W(LEN_W)) u_div_fac (
    .clk (clk),
    .en  (adv),
    .num (c_kprod),
    .den (c_side.len),
    .quo (fac_q)
  );

  dsf_div #(.NUM_W(WIDE_W), .DEN_W(LEN_W)) u_div_dldt (
    .clk (clk),
    .en  (adv),
    .num (c_dotmag),
    .den (c_side.len),
    .quo (dldt_q)
  );

  dsf_div #(.NUM_W(WIDE_W), .DEN_W(LEN_W)) u_div_mbar (
    .clk (clk),
    .en  (adv),
    .num (WIDE_W'(c_mprod)),
    .den (LEN_W'(c_msum)),
    .quo (mbar_q)
  );

  dsf_delay #(.WIDTH($bits(side_c_t)), .DEPTH(DIV_LAT)) u_dly_c (
    .clk  (clk),
    .en   (adv),
    .din  (c_side),
    .dout (sc_q)
  );

  // Scaled rate of stretch numerator and the damping gain.
  always_ff @(posedge clk) begin
    if (adv) begin
      d_side.geo    <= sc_q.geo;
      d_side.sneg   <= sc_q.sneg;
      d_side.dotneg <= sc_q.dotneg;
      d_side.don    <= sc_q.don;
      d_side.fac    <= sc_q.lnz ? fac_q : '0;
      d_side.gm     <= WIDE_W'(gm_full >> FRAC_BITS);
      d_snum        <= dldt_q << FRAC_BITS;
      d_len         <= sc_q.len;
    end
  end

  dsf_div #(.NUM_W(WIDE_W), .DEN_W(LEN_W)) u_div_s (
    .clk (clk),
    .en  (adv),
    .num (d_snum),
    .den (d_len),
    .quo (s_q)
  );

  dsf_delay #(.WIDTH($bits(side_d_t)), .DEPTH(DIV_LAT)) u_dly_d (
    .clk  (clk),
    .en   (adv),
    .din  (d_side),
    .dout (sd_q)
  );

  // Damping factor.
  dsf_mul u_mul_df (
    .clk (clk),
    .en  (adv),
    .a   (sd_q.gm),
    .b   (s_q),
    .res (df_res)
  );

  assign se_in.geo    = sd_q.geo;
  assign se_in.sneg   = sd_q.sneg;
  assign se_in.dotneg = sd_q.dotneg;
  assign se_in.don    = sd_q.don;
  assign se_in.fac    = sd_q.fac;

  dsf_delay #(.WIDTH($bits(side_e_t)), .DEPTH(MUL_LAT)) u_dly_e (
    .clk  (clk),
    .en   (adv),
    .din  (se_in),
    .dout (se_q)
  );

  // Elastic and damping magnitudes per axis.
  assign dm_a = se_q.don ? WIDE_W'(df_res.mag) : '0;

  for (genvar k = 0; k < 3; k++) begin : g_axis
    dsf_mul u_mul_e (
      .clk (clk),
      .en  (adv),
      .a   (se_q.fac),
      .b   (WIDE_W'(se_q.geo.mag[k])),
      .res (e_res[k])
    );

    dsf_mul u_mul_m (
      .clk (clk),
      .en  (adv),
      .a   (dm_a),
      .b   (WIDE_W'(se_q.geo.mag[k])),
      .res (m_res[k])
    );
  end

  assign sf_in.tag    = se_q.geo.tag;
  assign sf_in.sep    = se_q.geo.sep;
  assign sf_in.sneg   = se_q.sneg;
  assign sf_in.dotneg = se_q.dotneg;
  assign sf_in.dfsat  = se_q.don & df_res.sat;

  dsf_delay #(.WIDTH($bits(side_f_t)), .DEPTH(MUL_LAT)) u_dly_f (
    .clk  (clk),
    .en   (adv),
    .din  (sf_in),
    .dout (sf_q)
  );

  // Signs, difference and clamp to the word range.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e_s[k] = $signed(WIDE_W'(e_res[k].mag));
      if (sf_q.sneg == sf_q.sep[k][WORD_W-1]) begin
        e_s[k] = -e_s[k];
      end
      m_s[k] = $signed(WIDE_W'(m_res[k].mag));
      if (sf_q.dotneg != sf_q.sep[k][WORD_W-1]) begin
        m_s[k] = -m_s[k];
      end
      diff[k]  = e_s[k] - m_s[k];
      g_sat[k] = e_res[k].sat | m_res[k].sat | sf_q.dfsat;
      if (diff[k] > F_MAX) begin
        g_force[k] = F_MAX[WORD_W-1:0];
        g_sat[k]   = 1'b1;
      end else if (diff[k] < F_MIN) begin
        g_force[k] = F_MIN[WORD_W-1:0];
        g_sat[k]   = 1'b1;
      end else begin
        g_force[k] = diff[k][WORD_W-1:0];
      end
    end
  end

  // Output registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      tag_out  <= sf_q.tag;
      f_q      <= g_force;
      sep_q    <= sf_q.sep;
      overflow <= |g_sat;
    end
  end

  assign force_x = f_q[0];
  assign force_y = f_q[1];
  assign force_z = f_q[2];
  assign sep_x   = sep_q[0];
  assign sep_y   = sep_q[1];
  assign sep_z   = sep_q[2];

endmodule

`default_nettype wire

// File: rtl/core/dsf_delay.sv
`default_nettype none

module dsf_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] line [DEPTH];

  // Shift line that keeps side data level with a pipelined unit.
  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign dout = line[DEPTH-1];

endmodule

`default_nettype wire

// File: rtl/core/dsf_sqrt.sv
`default_nettype none

module dsf_sqrt import dsf_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [WIDE_W-1:0] rad,
  output logic [WORD_W-1:0] root
);

  localparam int STEPS = WIDE_W / 2;

  logic [WIDE_W-1:0] rem [STEPS];
  logic [WIDE_W-1:0] res [STEPS];

  // One result bit per stage, digit by digit from the top pair of bits.
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [WIDE_W-1:0] STEP_BIT = WIDE_W'(1) << (WIDE_W - 2 - 2 * i);
    logic [WIDE_W-1:0] rem_in;
    logic [WIDE_W-1:0] res_in;
    logic [WIDE_W-1:0] trial;
    logic              take;

    if (i == 0) begin : g_first
      assign rem_in = rad;
      assign res_in = '0;
    end else begin : g_rest
      assign rem_in = rem[i-1];
      assign res_in = res[i-1];
    end

    assign trial = res_in + STEP_BIT;
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= take ? rem_in - trial : rem_in;
        res[i] <= take ? (res_in >> 1) + STEP_BIT : res_in >> 1;
      end
    end
  end

  assign root = res[STEPS-1][WORD_W-1:0];

endmodule

`default_nettype wire

// File: rtl/core/dsf_div.sv
`default_nettype none

module dsf_div import dsf_pkg::*; #(
  parameter int NUM_W = WIDE_W,
  parameter int DEN_W = LEN_W
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  // acc holds the unused dividend bits at the top and the quotient at the bottom.
  logic [NUM_W-1:0] acc [NUM_W];
  logic [DEN_W-1:0] rem [NUM_W];
  logic [DEN_W-1:0] dv  [NUM_W-1];

  // Restoring division, one quotient bit per stage.
  for (genvar i = 0; i < NUM_W; i++) begin : g_step
    logic [NUM_W-1:0] acc_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (i == 0) begin : g_first
      assign acc_in = num;
      assign rem_in = '0;
      assign den_in = den;
    end else begin : g_rest
      assign acc_in = acc[i-1];
      assign rem_in = rem[i-1];
      assign den_in = dv[i-1];
    end

    assign trial = {rem_in, acc_in[NUM_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        acc[i] <= {acc_in[NUM_W-2:0], ge};
        rem[i] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      end
    end

    if (i < NUM_W - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          dv[i] <= den_in;
        end
      end
    end
  end

  assign quo = acc[NUM_W-1];

endmodule

`default_nettype wire

// File: rtl/core/dsf_mul.sv
`default_nettype none

module dsf_mul import dsf_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [WIDE_W-1:0] a,
  input  logic [WIDE_W-1:0] b,
  output prod_t             res
);

  localparam int HALF  = WIDE_W / 2;
  localparam int SHR_W = 2 * WIDE_W - FRAC_BITS;
  localparam logic [SHR_W-1:0] CAP = SHR_W'(1) << (MAG_W - 1);

  logic [WIDE_W-1:0]   ll, lh, hl, hh;
  logic [WIDE_W-1:0]   ll2, hh2;
  logic [WIDE_W:0]     mid;
  logic [2*WIDE_W-1:0] full;
  logic [SHR_W-1:0]    shifted;
  logic                over;

  assign shifted = full[2*WIDE_W-1:FRAC_BITS];
  assign over    = shifted > CAP;

  always_ff @(posedge clk) begin
    if (en) begin
      // Four half-width partial products.
      ll <= a[HALF-1:0]      * b[HALF-1:0];
      lh <= a[HALF-1:0]      * b[WIDE_W-1:HALF];
      hl <= a[WIDE_W-1:HALF] * b[HALF-1:0];
      hh <= a[WIDE_W-1:HALF] * b[WIDE_W-1:HALF];
      // Cross terms added together.
      mid <= {1'b0, lh} + {1'b0, hl};
      ll2 <= ll;
      hh2 <= hh;
      // Full product.
      full <= {hh2, ll2} + ({{(WIDE_W-1){1'b0}}, mid} << HALF);
      // Scale down and clamp.
      res.sat <= over;
      res.mag <= over ? CAP[MAG_W-1:0] : shifted[MAG_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import dsf_pkg::*;

  localparam int  HALF_PERIOD = 6;
  localparam int  SETTLE      = 220;
  localparam int  PHASE_ITEMS = 290;
  localparam logic [63:0] CAP = 64'd1 << 61;

  // One spring as presented on the input channel.
  typedef struct {
    logic [15:0]        tag;
    logic signed [31:0] off [3];
    logic signed [31:0] vel [3];
    logic [30:0]        m1, m2, ks, rs, gam;
  } spring_t;

  // One force result as seen on the output channel.
  typedef struct {
    logic [15:0]        tag;
    logic signed [31:0] frc [3];
    logic signed [31:0] sep [3];
    logic               ovf;
  } force_t;

  // Directed stimulus row; a typed expectation is used where given.
  typedef struct {
    spring_t sp;
    logic    typed;
    force_t  res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] spring_tag = '0;
  logic signed [31:0] offset_x = '0, offset_y = '0, offset_z = '0;
  logic signed [31:0] rel_vel_x = '0, rel_vel_y = '0, rel_vel_z = '0;
  logic [30:0] mass_first = '0, mass_second = '0, stiffness = '0;
  logic [30:0] rest_length = '0, damping = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] tag_out;
  logic signed [31:0] force_x, force_y, force_z, sep_x, sep_y, sep_z;
  logic overflow;

  force_t      force_q[$];
  logic [15:0] softening = SOFT_RESET;
  logic        typed_now = 1'b0;
  force_t      typed_res;
  logic        idle_on = 1'b1;
  int          fails = 0;
  int          stall_left = 0;

  damped_spring_force_top u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .spring_tag(spring_tag),
    .offset_x(offset_x), .offset_y(offset_y), .offset_z(offset_z),
    .rel_vel_x(rel_vel_x), .rel_vel_y(rel_vel_y), .rel_vel_z(rel_vel_z),
    .mass_first(mass_first), .mass_second(mass_second), .stiffness(stiffness),
    .rest_length(rest_length), .damping(damping),
    .out_valid(out_valid), .out_ready(out_ready), .tag_out(tag_out),
    .force_x(force_x), .force_y(force_y), .force_z(force_z),
    .sep_x(sep_x), .sep_y(sep_y), .sep_z(sep_z), .overflow(overflow)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Scaled product (a*b) >> FRAC_BITS, clamped to 2^61.
  function automatic logic [63:0] scaled_mul(input logic [63:0] a, input logic [63:0] b,
                                             inout logic sat);
    logic [127:0] prod;
    prod = ({64'd0, a} * {64'd0, b}) >> FRAC_BITS;
    if (prod > {64'd0, CAP}) begin
      sat = 1'b1;
      return CAP;
    end
    return prod[63:0];
  endfunction

  // Expected force for one spring at the given softening.
  function automatic force_t spring_force(input spring_t sp, input logic [15:0] soft_len);
    logic signed [63:0] d [3];
    logic signed [63:0] v [3];
    logic [63:0] ad [3];
    logic [63:0] sumsq, pos, neg, len, dotmag, fac, df, stretch;
    logic [63:0] mbar, gm, dldt, s, root, bitv, n, m1, m2;
    logic signed [63:0] p, e, dm, f;
    logic stretch_neg, dot_neg, damp_on, ovf, sat, dneg;
    force_t r;
    sumsq = 0; pos = 0; neg = 0; fac = 0; df = 0;
    dot_neg = 1'b0; ovf = 1'b0;
    m1 = sp.m1; m2 = sp.m2;
    for (int k = 0; k < 3; k++) begin
      d[k] = sp.off[k];
      v[k] = sp.vel[k];
      ad[k] = (d[k] < 0) ? -d[k] : d[k];
      sumsq += ad[k] * ad[k];
      p = d[k] * v[k];
      if (p < 0) neg += -p;
      else pos += p;
    end
    // Floor square root, bit by bit.
    n = sumsq; root = 0; bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    len = root + soft_len;
    stretch_neg = len < sp.rs;
    stretch = stretch_neg ? sp.rs - len : len - sp.rs;
    if (pos >= neg) begin
      dotmag = pos - neg;
    end else begin
      dotmag = neg - pos;
      dot_neg = 1'b1;
    end
    damp_on = (sp.gam != 0) && (m1 + m2 != 0) && (len != 0);
    if (len != 0) fac = (sp.ks * stretch) / len;
    if (damp_on) begin
      mbar = (m1 * m2) / (m1 + m2);
      gm = (sp.gam * mbar) >> FRAC_BITS;
      dldt = dotmag / len;
      s = (dldt << FRAC_BITS) / len;
      df = scaled_mul(gm, s, ovf);
    end
    r.tag = sp.tag;
    r.ovf = 1'b0;
    for (int k = 0; k < 3; k++) begin
      sat = ovf;
      dneg = d[k] < 0;
      e = scaled_mul(fac, ad[k], sat);
      if (stretch_neg == dneg) e = -e;
      dm = 0;
      if (damp_on) begin
        dm = scaled_mul(df, ad[k], sat);
        if (dot_neg != dneg) dm = -dm;
      end
      f = e - dm;
      if (f > 64'sd2147483647) begin
        f = 64'sd2147483647;
        sat = 1'b1;
      end else if (f < -64'sd2147483648) begin
        f = -64'sd2147483648;
        sat = 1'b1;
      end
      r.ovf |= sat;
      r.frc[k] = f[31:0];
      r.sep[k] = sp.off[k];
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  // Gap lengths: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Signed operand: mostly plausible magnitudes, some full-range and extremes.
  function automatic logic signed [31:0] rnd_word();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'sh8000_0000;
      2: return 32'sh7fff_ffff;
      3: return '0;
      4, 5: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  function automatic logic [30:0] rnd_mag();
    case ($urandom_range(0, 7))
      0: return 31'($urandom);
      1: return 31'h7fff_ffff;
      2: return '0;
      3, 4: return 31'($urandom_range(0, 32'h0004_0000));
      default: return 31'($urandom_range(0, 32'h0200_0000));
    endcase
  endfunction

  function automatic spring_t rnd_spring();
    spring_t sp;
    sp.tag = 16'($urandom);
    for (int k = 0; k < 3; k++) begin
      sp.off[k] = rnd_word();
      sp.vel[k] = rnd_word();
    end
    sp.m1 = rnd_mag(); sp.m2 = rnd_mag(); sp.ks = rnd_mag();
    sp.rs = rnd_mag(); sp.gam = rnd_mag();
    return sp;
  endfunction

  function automatic spring_t zero_spring();
    spring_t sp;
    sp.tag = '0;
    for (int k = 0; k < 3; k++) begin
      sp.off[k] = '0;
      sp.vel[k] = '0;
    end
    sp.m1 = '0; sp.m2 = '0; sp.ks = '0; sp.rs = '0; sp.gam = '0;
    return sp;
  endfunction

  // Present one request and hold it until it is taken.
  task automatic send(input spring_t sp, input logic typed, input force_t res);
    int g;
    @(negedge clk);
    typed_now = typed;
    typed_res = res;
    spring_tag = sp.tag;
    offset_x = sp.off[0]; offset_y = sp.off[1]; offset_z = sp.off[2];
    rel_vel_x = sp.vel[0]; rel_vel_y = sp.vel[1]; rel_vel_z = sp.vel[2];
    mass_first = sp.m1; mass_second = sp.m2; stiffness = sp.ks;
    rest_length = sp.rs; damping = sp.gam;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (force_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_softening(input logic [15:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = val;
    softening = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Output side: random back-pressure driven at the falling edge.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left <= gap_len();
    end
  end

  // Check results and record expectations for accepted requests.
  always @(posedge clk) begin
    force_t want;
    spring_t sp;
    if (!rst && out_valid && out_ready) begin
      if (force_q.size() == 0) begin
        report("unexpected result", {16'd0, tag_out}, 32'd0);
      end else begin
        want = force_q.pop_front();
        if (tag_out !== want.tag) report("tag_out", {16'd0, tag_out}, {16'd0, want.tag});
        if (force_x !== want.frc[0]) report("force_x", force_x, want.frc[0]);
        if (force_y !== want.frc[1]) report("force_y", force_y, want.frc[1]);
        if (force_z !== want.frc[2]) report("force_z", force_z, want.frc[2]);
        if (sep_x !== want.sep[0]) report("sep_x", sep_x, want.sep[0]);
        if (sep_y !== want.sep[1]) report("sep_y", sep_y, want.sep[1]);
        if (sep_z !== want.sep[2]) report("sep_z", sep_z, want.sep[2]);
        if (overflow !== want.ovf) report("overflow", {31'd0, overflow}, {31'd0, want.ovf});
      end
    end
    if (!rst && in_valid && in_ready) begin
      if (typed_now) begin
        force_q.push_back(typed_res);
      end else begin
        sp.tag = spring_tag;
        sp.off[0] = offset_x; sp.off[1] = offset_y; sp.off[2] = offset_z;
        sp.vel[0] = rel_vel_x; sp.vel[1] = rel_vel_y; sp.vel[2] = rel_vel_z;
        sp.m1 = mass_first; sp.m2 = mass_second; sp.ks = stiffness;
        sp.rs = rest_length; sp.gam = damping;
        force_q.push_back(spring_force(sp, softening));
      end
    end
  end

  // Main sequence.
  initial begin
    row_t rows[$];
    row_t rw;
    force_t none;
    logic [15:0] soft_plan [5];
    none = spring_force(zero_spring(), 16'd1);

    // All zero: no force, separation zero.
    rw.sp = zero_spring(); rw.typed = 1'b1; rw.res = none;
    rows.push_back(rw);
    // Unit stretch along x with unit stiffness pulls back by one.
    rw.sp = zero_spring(); rw.sp.tag = 16'hffff;
    rw.sp.off[0] = 32'sh0001_0000; rw.sp.ks = 31'h0001_0000;
    rw.typed = 1'b1; rw.res = none; rw.res.tag = 16'hffff;
    rw.res.sep[0] = 32'sh0001_0000; rw.res.frc[0] = -32'sh0001_0000;
    rows.push_back(rw);
    rw.typed = 1'b0;
    // Largest positive offsets and stiffness: saturation.
    rw.sp = zero_spring(); rw.sp.tag = 16'h00a5;
    for (int k = 0; k < 3; k++) rw.sp.off[k] = 32'sh7fff_ffff;
    rw.sp.ks = 31'h7fff_ffff;
    rows.push_back(rw);
    // Most negative offsets, stretched spring.
    rw.sp = zero_spring(); rw.sp.tag = 16'h5a00;
    for (int k = 0; k < 3; k++) rw.sp.off[k] = 32'sh8000_0000;
    rw.sp.ks = 31'h0000_8000; rw.sp.rs = 31'h7fff_ffff;
    rows.push_back(rw);
    // Damping with zero mass sum is dropped.
    rw.sp = zero_spring(); rw.sp.tag = 16'h0003;
    rw.sp.off[1] = 32'sh0002_0000; rw.sp.vel[1] = 32'sh0001_0000;
    rw.sp.ks = 31'h0001_0000; rw.sp.gam = 31'h7fff_ffff;
    rows.push_back(rw);
    // Ordinary damped spring, opposing velocity.
    rw.sp.tag = 16'h0004; rw.sp.m1 = 31'h0001_0000; rw.sp.m2 = 31'h0003_0000;
    rw.sp.gam = 31'h0000_8000; rw.sp.vel[1] = -32'sh0004_0000; rw.sp.off[2] = -32'sh0001_0000;
    rows.push_back(rw);
    // Extreme masses, damping and velocities: damping term saturates.
    rw.sp = zero_spring(); rw.sp.tag = 16'h0005;
    rw.sp.m1 = 31'h7fff_ffff; rw.sp.m2 = 31'h7fff_ffff; rw.sp.gam = 31'h7fff_ffff;
    for (int k = 0; k < 3; k++) begin
      rw.sp.off[k] = 32'sh0000_0100;
      rw.sp.vel[k] = 32'sh7fff_ffff;
    end
    rows.push_back(rw);
    // Tiny offsets, rest length longer than the spring, mixed signs.
    rw.sp = zero_spring(); rw.sp.tag = 16'h0006;
    rw.sp.off[0] = 32'sh0000_0001; rw.sp.off[1] = -32'sh0000_0001;
    rw.sp.vel[2] = 32'sh8000_0000; rw.sp.ks = 31'h7fff_ffff; rw.sp.rs = 31'h0000_0100;
    rw.sp.m1 = 31'h0000_0001; rw.sp.gam = 31'h0000_0001;
    rows.push_back(rw);
    // Dead spring with damping only.
    rw.sp = rnd_spring(); rw.sp.ks = '0;
    rows.push_back(rw);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) send(rows[i].sp, rows[i].typed, rows[i].res);
    drain();

    // Random phases across softening settings, extremes included.
    soft_plan[0] = 16'd0;
    soft_plan[1] = 16'hffff;
    soft_plan[2] = 16'($urandom);
    soft_plan[3] = 16'd1;
    soft_plan[4] = 16'($urandom_range(0, 255));
    for (int ph = 0; ph < 5; ph++) begin
      write_softening(soft_plan[ph]);
      idle_on = (ph != 2);
      // Zero length spring, meaningful when softening is zero.
      rw.sp = rnd_spring();
      for (int k = 0; k < 3; k++) rw.sp.off[k] = '0;
      send(rw.sp, 1'b0, none);
      for (int i = 0; i < PHASE_ITEMS - 1; i++) send(rnd_spring(), 1'b0, none);
      drain();
    end
    idle_on = 1'b1;

    if (fails == 0) begin
      $display("[damped_spring_force_top] OK");
    end else begin
      $display("[damped_spring_force_top] ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("[damped_spring_force_top] ERROR");
    $finish;
  end

endmodule

// File: damped_spring_force_top.f
rtl/core/dsf_pkg.sv
rtl/core/dsf_delay.sv
rtl/core/dsf_sqrt.sv
rtl/core/dsf_div.sv
rtl/core/dsf_mul.sv
rtl/core/damped_spring_force_top.sv
tb/tb.sv
